/* hw/rtl/hdlcr_pkg.sv */
package hdlcr_pkg;

  localparam int RX_W    = 8;
  localparam int KIND_W  = 3;
  localparam int OCTET_W = 8;
  localparam int LEN_W   = 10;
  localparam int CRC_W   = 16;
  localparam int WIN_W   = 16;
  localparam int FILL_W  = 4;
  localparam int CIDX_W  = 4;

  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_FLAG = 2'd2;

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;

  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CRC_BAD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STUFF    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG = 3'd5;
  localparam logic [KIND_W-1:0] KIND_MID_FLAG = 3'd6;

  localparam logic [CIDX_W-1:0] CFG_MIN_LEN = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_LEN = 4'd1;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 10'd16;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd330;

  localparam logic [CRC_W-1:0] CRC_PRESET = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY   = 16'h8408;

  typedef struct packed {
    logic       first;
    logic [1:0] code;
  } sym_t;

  typedef struct packed {
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
  } cfg_t;

endpackage

/* hw/rtl/hdlcr_if.sv */
interface hdlcr_in_if;
  logic                         valid;
  logic                         ready;
  logic [hdlcr_pkg::RX_W-1:0]   rx_bits;
  modport source (output valid, output rx_bits, input ready);
  modport sink (input valid, input rx_bits, output ready);
endinterface

interface hdlcr_out_if;
  logic                          valid;
  logic                          ready;
  logic [hdlcr_pkg::KIND_W-1:0]  kind;
  logic [hdlcr_pkg::OCTET_W-1:0] octet;
  logic                          last;
  modport source (output valid, output kind, output octet, output last, input ready);
  modport sink (input valid, input kind, input octet, input last, output ready);
endinterface

interface hdlcr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hdlcr_pkg::CIDX_W-1:0] index;
  logic [hdlcr_pkg::LEN_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/hdlcr_front.sv */
module hdlcr_front (
  input  logic              clk,
  input  logic              rst_n,
  hdlcr_in_if.sink          in_ch,
  output logic              push,
  output hdlcr_pkg::sym_t   push_sym,
  input  logic              full
);
  import hdlcr_pkg::*;

  logic [WIN_W-1:0]  window_r, window_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              first_r, first_nxt;
  logic              take;
  logic              is_flag;
  logic [WIN_W-1:0]  in_shifted;

  assign in_ch.ready = ~fill_r[FILL_W-1];
  assign take        = in_ch.valid & ~fill_r[FILL_W-1];
  assign is_flag     = (window_r[7:0] == FLAG_PATTERN);
  assign push        = fill_r[FILL_W-1] & ~full;
  assign in_shifted  = {{(WIN_W-RX_W){1'b0}}, in_ch.rx_bits} << fill_r[2:0];

  always_comb begin
    window_nxt     = window_r;
    fill_nxt       = fill_r;
    first_nxt      = first_r;
    push_sym.first = first_r;
    push_sym.code  = is_flag ? SYM_FLAG : (window_r[0] ? SYM_ONE : SYM_ZERO);
    if (take) begin
      window_nxt = window_r | in_shifted;
      fill_nxt   = fill_r + 4'd8;
      first_nxt  = 1'b1;
    end else if (push) begin
      first_nxt = 1'b0;
      if (is_flag) begin
        window_nxt = window_r >> 8;
        fill_nxt   = fill_r - 4'd8;
      end else begin
        window_nxt = window_r >> 1;
        fill_nxt   = fill_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '1;
      fill_r   <= '0;
      first_r  <= 1'b0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

/* hw/rtl/hdlcr_sym_fifo.sv */
module hdlcr_sym_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hdlcr_pkg::sym_t push_sym,
  output logic            full,
  input  logic            pop,
  output hdlcr_pkg::sym_t pop_sym,
  output logic            empty
);
  import hdlcr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sym_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign pop_sym = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/hdlcr_back.sv */
module hdlcr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  hdlcr_pkg::cfg_t cfg,
  input  hdlcr_pkg::sym_t sym,
  input  logic            empty,
  output logic            pop,
  hdlcr_out_if.source     out_ch
);
  import hdlcr_pkg::*;

  localparam logic [1:0] MODE_HUNT = 2'd0;
  localparam logic [1:0] MODE_SYNC = 2'd1;
  localparam logic [1:0] MODE_RECV = 2'd2;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [1:0]         mode_r, mode_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [2:0]         bit_idx_r, bit_idx_nxt;
  logic [2:0]         ones_r, ones_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [7:0]         held0_r, held0_nxt;
  logic [7:0]         held1_r, held1_nxt;
  logic [1:0]         held_cnt_r, held_cnt_nxt;
  logic [1:0]         step_cnt_r, step_cnt_nxt;
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [OCTET_W-1:0] out_octet_r;
  logic               out_last_r;

  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [7:0]         emit_octet;
  logic               do_complete;
  logic [7:0]         comp_octet;
  logic [1:0]         eff_cnt;
  logic               send;
  logic [LEN_W:0]     short_limit;
  logic [CRC_W-1:0]   fcs;

  assign pop          = ~empty & (~out_valid_r | out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.octet = out_octet_r;
  assign out_ch.last  = out_last_r;
  assign short_limit  = {1'b0, cfg.min_len} + 11'd2;
  assign fcs          = ~{held1_r, held0_r};
  assign eff_cnt      = sym.first ? 2'd0 : step_cnt_r;
  assign send         = pop & emit & (eff_cnt != 2'd2);

  always_comb begin
    mode_nxt     = mode_r;
    shift_nxt    = shift_r;
    bit_idx_nxt  = bit_idx_r;
    ones_nxt     = ones_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    emit         = 1'b0;
    emit_kind    = KIND_DATA;
    emit_octet   = '0;
    do_complete  = 1'b0;
    comp_octet   = '0;
    if (pop) begin
      case (mode_r)
        MODE_RECV: begin
          if (ones_r >= 3'd5) begin
            if (sym.code != SYM_ZERO) begin
              emit      = 1'b1;
              emit_kind = KIND_STUFF;
              mode_nxt  = MODE_HUNT;
            end else begin
              ones_nxt = '0;
              if (bit_idx_r == '0) begin
                do_complete = 1'b1;
                comp_octet  = shift_r;
              end
            end
          end else if (sym.code == SYM_FLAG) begin
            emit     = 1'b1;
            mode_nxt = MODE_SYNC;
            if (bit_idx_r != '0) begin
              emit_kind = KIND_MID_FLAG;
            end else if ({1'b0, len_r} <= short_limit) begin
              emit_kind = KIND_SHORT;
            end else if (crc_r == fcs) begin
              emit_kind = KIND_GOOD;
            end else begin
              emit_kind = KIND_CRC_BAD;
            end
          end else if (bit_idx_r == '0 && len_r > cfg.max_len) begin
            emit      = 1'b1;
            emit_kind = KIND_TOO_LONG;
            mode_nxt  = MODE_HUNT;
          end else begin
            shift_nxt   = {sym.code[0], shift_r[7:1]};
            ones_nxt    = sym.code[0] ? ones_r + 3'd1 : 3'd0;
            bit_idx_nxt = bit_idx_r + 3'd1;
            if (ones_nxt < 3'd5 && bit_idx_nxt == '0) begin
              do_complete = 1'b1;
              comp_octet  = shift_nxt;
            end
          end
        end
        MODE_SYNC: begin
          if (sym.code != SYM_FLAG) begin
            mode_nxt     = MODE_RECV;
            shift_nxt    = {sym.code[0], 7'b0};
            ones_nxt     = {2'b00, sym.code[0]};
            bit_idx_nxt  = 3'd1;
            len_nxt      = '0;
            crc_nxt      = CRC_PRESET;
            held_cnt_nxt = '0;
          end
        end
        default: begin
          if (sym.code == SYM_FLAG) begin
            mode_nxt = MODE_SYNC;
          end
        end
      endcase
      if (do_complete) begin
        if (held_cnt_r[1]) begin
          emit       = 1'b1;
          emit_kind  = KIND_DATA;
          emit_octet = held0_r;
          crc_nxt    = crc_byte(crc_r, held0_r);
          held0_nxt  = held1_r;
          held1_nxt  = comp_octet;
        end else begin
          if (held_cnt_r[0]) begin
            held1_nxt = comp_octet;
          end else begin
            held0_nxt = comp_octet;
          end
          held_cnt_nxt = held_cnt_r + 2'd1;
        end
        if (len_r != '1) begin
          len_nxt = len_r + LEN_W'(1);
        end
      end
    end
  end

  always_comb begin
    step_cnt_nxt = step_cnt_r;
    if (pop) begin
      step_cnt_nxt = send ? eff_cnt + 2'd1 : eff_cnt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    held0_r   <= held0_nxt;
    held1_r   <= held1_nxt;
    crc_r     <= crc_nxt;
    if (send) begin
      out_kind_r  <= emit_kind;
      out_octet_r <= (emit_kind == KIND_DATA) ? emit_octet : 8'h00;
      out_last_r  <= (emit_kind != KIND_DATA);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_HUNT;
      bit_idx_r   <= '0;
      ones_r      <= '0;
      len_r       <= '0;
      held_cnt_r  <= '0;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      bit_idx_r  <= bit_idx_nxt;
      ones_r     <= ones_nxt;
      len_r      <= len_nxt;
      held_cnt_r <= held_cnt_nxt;
      step_cnt_r <= step_cnt_nxt;
      if (send) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/hdlc_frame_receiver_unit.sv */
// Channel  Modport  Fields                    Transaction
// in_ch    sink     rx_bits[7:0]              valid && ready
// out_ch   source   kind[2:0] octet[7:0] last valid && ready
// cfg_ch   sink     index[3:0] data[9:0]      valid && ready (ready is always high)
//
// An input transaction loads a byte into the bit window, which yields one symbol per cycle
// while the symbol queue is not full, and takes the next byte once under eight bits remain.
// The symbol decoder handles one queued symbol per cycle, including an octet's CRC update, unless the output stalls.
// Reset is synchronous and active low; the frame length registers return to 16 and 330.
// A stalled output holds the decoder while the symbol queue between the two halves fills.
module hdlc_frame_receiver_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  hdlcr_in_if.sink     in_ch,
  hdlcr_out_if.source  out_ch,
  hdlcr_cfg_if.sink    cfg_ch
);
  import hdlcr_pkg::*;

  cfg_t cfg_r;
  sym_t push_sym, pop_sym;
  logic push, full, pop, empty;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len <= MIN_LEN_RESET;
      cfg_r.max_len <= MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_MIN_LEN) begin
        cfg_r.min_len <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_MAX_LEN) begin
        cfg_r.max_len <= cfg_ch.data;
      end
    end
  end

  hdlcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_sym (push_sym),
    .full     (full)
  );

  hdlcr_sym_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_sym (push_sym),
    .full     (full),
    .pop      (pop),
    .pop_sym  (pop_sym),
    .empty    (empty)
  );

  hdlcr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .sym    (pop_sym),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* sim/hdlc_frame_receiver_check.sv */
`timescale 1ns / 100ps

module hdlc_frame_receiver_check (
  input  logic  clk,
  input  logic  rst_n,
  hdlcr_in_if   in_ch,
  hdlcr_out_if  out_ch,
  hdlcr_cfg_if  cfg_ch,
  output int    fail_count,
  output int    pending
);
  import hdlcr_pkg::*;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_SYNC,
    MODE_RECV
  } rx_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [OCTET_W-1:0] octet;
    logic               last;
  } rx_result_t;

  rx_result_t         expected_q[$];
  int                 errors = 0;
  int                 step_results;

  logic [LEN_W-1:0]   min_len;
  logic [LEN_W-1:0]   max_len;
  logic [WIN_W-1:0]   window;
  int                 fill;
  rx_mode_t           mode;
  logic [7:0]         shreg;
  logic [2:0]         bit_idx;
  int                 ones;
  logic [LEN_W-1:0]   octet_count;
  logic [CRC_W-1:0]   crc;
  logic [7:0]         held [2];
  int                 held_n;

  function automatic void push_result(logic [KIND_W-1:0] kind, logic [7:0] oct);
    rx_result_t r;
    if (step_results >= 2) return;
    r.kind  = kind;
    r.octet = (kind == KIND_DATA) ? oct : '0;
    r.last  = (kind != KIND_DATA);
    expected_q.push_back(r);
    step_results++;
  endfunction

  // Octets are held back by two so that the FCS never reaches the output.
  function automatic void finish_octet();
    logic [CRC_W-1:0] c;
    if (held_n >= 2) begin
      push_result(KIND_DATA, held[0]);
      c = crc ^ {8'h00, held[0]};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      crc     = c;
      held[0] = held[1];
      held[1] = shreg;
    end else begin
      held[held_n] = shreg;
      held_n++;
    end
    if (octet_count != '1) octet_count++;
  endfunction

  function automatic void take_data_bit(logic b);
    if (bit_idx == 0 && octet_count > max_len) begin
      push_result(KIND_TOO_LONG, '0);
      mode = MODE_HUNT;
      return;
    end
    shreg = {b, shreg[7:1]};
    ones  = b ? ones + 1 : 0;
    bit_idx++;
    if (ones < 5 && bit_idx == 0) finish_octet();
  endfunction

  function automatic void take_symbol(logic [1:0] s);
    logic [CRC_W-1:0] fcs;
    case (mode)
      MODE_RECV: begin
        if (ones >= 5) begin
          if (s != SYM_ZERO) begin
            push_result(KIND_STUFF, '0);
            mode = MODE_HUNT;
          end else begin
            ones = 0;
            if (bit_idx == 0) finish_octet();
          end
        end else if (s == SYM_FLAG) begin
          if (bit_idx != 0) begin
            push_result(KIND_MID_FLAG, '0);
          end else begin
            fcs = {~held[1], ~held[0]};
            if (int'(octet_count) <= int'(min_len) + 2) push_result(KIND_SHORT, '0);
            else if (crc == fcs) push_result(KIND_GOOD, '0);
            else push_result(KIND_CRC_BAD, '0);
          end
          mode = MODE_SYNC;
        end else begin
          take_data_bit(s[0]);
        end
      end
      MODE_SYNC: begin
        if (s != SYM_FLAG) begin
          mode        = MODE_RECV;
          bit_idx     = '0;
          ones        = 0;
          octet_count = '0;
          shreg       = '0;
          crc         = CRC_PRESET;
          held_n      = 0;
          take_data_bit(s[0]);
        end
      end
      default: begin
        if (s == SYM_FLAG) mode = MODE_SYNC;
      end
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] rx);
    logic [1:0] s;
    step_results = 0;
    fill   = fill & 7;
    window = window | ({8'h00, rx} << fill);
    fill  += 8;
    while (fill >= 8) begin
      if (window[7:0] == FLAG_PATTERN) begin
        window = window >> 8;
        fill  -= 8;
        s      = SYM_FLAG;
      end else begin
        s      = window[0] ? SYM_ONE : SYM_ZERO;
        window = window >> 1;
        fill  -= 1;
      end
      take_symbol(s);
    end
  endfunction

  function automatic void reset_model();
    min_len     = MIN_LEN_RESET;
    max_len     = MAX_LEN_RESET;
    window      = '1;
    fill        = 0;
    mode        = MODE_HUNT;
    shreg       = '0;
    bit_idx     = '0;
    ones        = 0;
    octet_count = '0;
    crc         = CRC_PRESET;
    held[0]     = '0;
    held[1]     = '0;
    held_n      = 0;
    expected_q.delete();
  endfunction

  always @(posedge clk) begin
    rx_result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with none expected: kind %0d, octet %02h, last %0d",
                 out_ch.kind, out_ch.octet, out_ch.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
            errors++;
          end
          if (out_ch.octet !== want.octet) begin
            $error("octet: expected %02h, actual %02h", want.octet, out_ch.octet);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_ch.last);
            errors++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_MIN_LEN) min_len = cfg_ch.data;
        else if (cfg_ch.index == CFG_MAX_LEN) max_len = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.rx_bits);
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

/* sim/hdlc_frame_receiver_unit_test.sv */
`timescale 1ns / 100ps

module hdlc_frame_receiver_unit_test;
  import hdlcr_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_BYTES   = 170;
  localparam int PHASE_COUNT   = 8;

  localparam logic [CIDX_W-1:0] CFG_UNUSED = 4'hF;

  logic clk;
  logic rst_n;

  hdlcr_in_if  in_ch ();
  hdlcr_out_if out_ch ();
  hdlcr_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int cycle_count = 0;

  bit line_bits[$];
  int tx_ones     = 0;
  int bytes_sent  = 0;
  bit tx_idle_on  = 1'b1;
  bit tx_quiet    = 1'b0;
  bit rx_stall_on = 1'b1;
  bit rx_quiet    = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  logic [LEN_W-1:0] cur_min;
  logic [LEN_W-1:0] cur_max;

  hdlc_frame_receiver_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  hdlc_frame_receiver_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_stall_on && !rx_quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
        @(posedge clk);
      end
    end
  end

  function automatic void put_bit(bit b);
    line_bits.push_back(b);
  endfunction

  function automatic void put_flag();
    for (int i = 0; i < 8; i++) put_bit(FLAG_PATTERN[i]);
    tx_ones = 0;
  endfunction

  function automatic void put_data_bit(bit b);
    put_bit(b);
    tx_ones = b ? tx_ones + 1 : 0;
    if (tx_ones == 5) begin
      put_bit(1'b0);
      tx_ones = 0;
    end
  endfunction

  function automatic void put_octet(logic [7:0] o);
    for (int i = 0; i < 8; i++) put_data_bit(o[i]);
  endfunction

  function automatic logic [7:0] pick_octet();
    return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
  endfunction

  function automatic void put_frame(int n, bit bad_fcs);
    logic [CRC_W-1:0] c;
    logic [7:0]       o;
    logic [15:0]      fcs;
    c = CRC_PRESET;
    for (int k = 0; k < n; k++) begin
      o = pick_octet();
      put_octet(o);
      c = c ^ {8'h00, o};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    fcs = ~c;
    if (bad_fcs) fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
    put_octet(fcs[7:0]);
    put_octet(fcs[15:8]);
    put_flag();
  endfunction

  function automatic void put_random_unit();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(0, (cur_min > 18) ? 24 : int'(cur_min) + 6);
    if (pick < 55) begin
      put_frame(len, 1'b0);
    end else if (pick < 67) begin
      put_frame(len, 1'b1);
    end else if (pick < 75) begin
      repeat ($urandom_range(0, 3)) put_octet(pick_octet());
      repeat (7) put_bit(1'b1);
      put_flag();
    end else if (pick < 83) begin
      repeat ($urandom_range(0, 3)) put_octet(pick_octet());
      repeat ($urandom_range(1, 7)) put_data_bit(1'($urandom_range(0, 1)));
      put_flag();
    end else if (pick < 90) begin
      if (cur_max <= 40) put_frame(int'(cur_max) + $urandom_range(0, 3), 1'b0);
      else put_frame(len, 1'b0);
    end else if (pick < 96) begin
      repeat ($urandom_range(8, 32)) put_bit(1'($urandom_range(0, 1)));
      put_flag();
      put_flag();
    end else begin
      repeat ($urandom_range(8, 16)) put_bit(1'b1);
      put_flag();
    end
    repeat ($urandom_range(0, 2)) put_flag();
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_on && !tx_quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_bits <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flush_line();
    while (line_bits.size() >= 8) begin
      logic [7:0] b;
      for (int i = 0; i < 8; i++) b[i] = line_bits.pop_front();
      send_byte(b);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  initial begin
    int target;
    in_ch.valid   <= 1'b0;
    in_ch.rx_bits <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    rst_n         <= 1'b0;
    cur_min = MIN_LEN_RESET;
    cur_max = MAX_LEN_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    repeat (8) put_bit(1'b0);
    repeat (8) put_bit(1'b1);
    put_flag();
    put_flag();
    put_frame(3, 1'b0);
    put_flag();
    put_octet(8'h55);
    repeat (7) put_bit(1'b1);
    put_flag();
    repeat (5) put_bit(1'b1);
    put_flag();
    put_flag();
    put_data_bit(1'b1);
    put_data_bit(1'b0);
    put_data_bit(1'b1);
    put_flag();
    put_frame(0, 1'b0);
    flush_line();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      case (p)
        0: begin
          cur_min = 10'd0;
          cur_max = 10'd1;
        end
        1: begin
          cur_min = 10'd2;
          cur_max = 10'd40;
        end
        2: begin
          cur_min = 10'd1023;
          cur_max = 10'd1023;
        end
        3: begin
          cur_min = 10'd5;
          cur_max = 10'd20;
        end
        4: begin
          cur_min = 10'd0;
          cur_max = 10'd1023;
        end
        default: begin
          cur_min = 10'($urandom_range(0, 12));
          cur_max = 10'($urandom_range(8, 60));
        end
      endcase
      write_reg(CFG_MIN_LEN, cur_min);
      write_reg(CFG_MAX_LEN, cur_max);
      if (p == 0) write_reg(CFG_UNUSED, 10'($urandom));
      cfg_ch.valid <= 1'b0;
      if (p == PHASE_COUNT - 1) begin
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
      end
      if (p == 1) hold_req = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        put_random_unit();
        flush_line();
        if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
